// ===== hdl/cbm_pkg.sv =====
// cbm_pkg: shared types, codes and constants of the cartridge bank mapper.
// Used by cbm_datapath, cbm_ctrl and cartridge_bank_mapper_irq.
`default_nettype none

package cbm_pkg;

	localparam int PRESCALE_PERIOD_DEF = 341;
	localparam int PRESCALE_W          = 9;
	localparam int IRQ_COUNT_W         = 9;
	localparam int MEM_ADDR_W          = 21;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [2:0] TGT_NONE  = 3'd0;
	localparam logic [2:0] TGT_CHR   = 3'd1;
	localparam logic [2:0] TGT_SRAM  = 3'd2;
	localparam logic [2:0] TGT_PRG   = 3'd3;
	localparam logic [2:0] TGT_CONST = 3'd4;

	localparam logic        CFG_PRG_COUNT = 1'b0;
	localparam logic        CFG_CHR_COUNT = 1'b1;

	localparam logic [15:0] DEC_MASK     = 16'hF030;
	localparam logic [15:0] DEC_PRG0     = 16'h8000;
	localparam logic [15:0] DEC_PRG1     = 16'h8010;
	localparam logic [15:0] DEC_PRG2     = 16'h9000;
	localparam logic [15:0] DEC_AUD_IDX  = 16'h9010;
	localparam logic [15:0] DEC_AUD_DATA = 16'h9030;
	localparam logic [15:0] DEC_CHR0     = 16'hA000;
	localparam logic [15:0] DEC_CHR1     = 16'hA010;
	localparam logic [15:0] DEC_CHR2     = 16'hB000;
	localparam logic [15:0] DEC_CHR3     = 16'hB010;
	localparam logic [15:0] DEC_CHR4     = 16'hC000;
	localparam logic [15:0] DEC_CHR5     = 16'hC010;
	localparam logic [15:0] DEC_CHR6     = 16'hD000;
	localparam logic [15:0] DEC_CHR7     = 16'hD010;
	localparam logic [15:0] DEC_MIRROR   = 16'hE000;
	localparam logic [15:0] DEC_IRQ_LAT  = 16'hE010;
	localparam logic [15:0] DEC_IRQ_CTRL = 16'hF000;
	localparam logic [15:0] DEC_IRQ_ACK  = 16'hF010;

	localparam logic [7:0]  MIRROR_MASK  = 8'hC3;
	localparam logic [7:0]  RAM_OFF_VAL  = 8'hFF;
	localparam logic [8:0]  IRQ_WRAP     = 9'h100;

	typedef struct packed {
		logic load_in;
		logic mod_start;
		logic commit;
	} cbm_cmd_t;

	typedef struct packed {
		logic need_mod;
		logic mod_done;
	} cbm_stat_t;

endpackage

`default_nettype wire

// ===== hdl/cartridge_bank_mapper_irq.sv =====
// cartridge_bank_mapper_irq: bank-switching cartridge mapper with IRQ timer.
// Instantiates cbm_ctrl and cbm_datapath; depends on cbm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word: op, addr, data. Op is a
//   bus read, a bus write or one timer tick. Output channel (out_valid/
//   out_ready) returns exactly one result word per input word, in order.
//   Config port: cfg_we with cfg_index (0 program bank count, 1 pattern bank
//   count) and cfg_data; the user writes only while the block is idle (unenforced).
// Processing:
//   Words needing a bank modulo (pattern accesses, program reads in the
//   switchable windows) pass through ST_DIV: the bank number goes through
//   an 8-step shift-subtract remainder unit. All other words go from ST_START
//   straight to ST_OUT. One word is in work at a time; the next word is
//   accepted once the result is in the output register.
// Reset: arst_n clears all bank, IRQ and prescaler registers; bank counts
//   reset to 1. No clearing pass.
// Stall: a result held by out_ready low keeps its word in the output
//   register; the next word is processed but waits to commit behind it.
`default_nettype none

module cartridge_bank_mapper_irq #(
	parameter int PRESCALE_PERIOD = cbm_pkg::PRESCALE_PERIOD_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [7:0]                cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                op,
	input  wire logic [15:0]               addr,
	input  wire logic [7:0]                data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2:0]                     target,
	output logic [cbm_pkg::MEM_ADDR_W-1:0] mem_addr,
	output logic                           is_write,
	output logic [7:0]                     write_data,
	output logic [7:0]                     const_value,
	output logic                           audio_write,
	output logic [7:0]                     audio_reg,
	output logic [1:0]                     mirror_mode,
	output logic                           irq_pulse,
	output logic                           unhandled
);

	cbm_pkg::cbm_cmd_t  cmd;
	cbm_pkg::cbm_stat_t stat;

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbm_datapath #(
		.PRESCALE_PERIOD (PRESCALE_PERIOD)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.addr        (addr),
		.data        (data),
		.target      (target),
		.mem_addr    (mem_addr),
		.is_write    (is_write),
		.write_data  (write_data),
		.const_value (const_value),
		.audio_write (audio_write),
		.audio_reg   (audio_reg),
		.mirror_mode (mirror_mode),
		.irq_pulse   (irq_pulse),
		.unhandled   (unhandled)
	);

endmodule

`default_nettype wire

// ===== hdl/cbm_mod_unit.sv =====
// cbm_mod_unit: 8-bit remainder unit, restoring, one quotient bit per cycle.
// Standalone; used by cbm_datapath for bank-number modulo.
`default_nettype none

module cbm_mod_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] dividend,
	input  wire logic [7:0] divisor,
	output logic [7:0]      remainder,
	output logic            done
);

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] quo_q;
	logic [7:0] rem_q;
	logic [7:0] div_q;
	logic [8:0] trial;
	logic [7:0] rem_next;

	always_comb begin
		trial = {rem_q, quo_q[7]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = 8'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[6:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign remainder = rem_q;
	assign done      = done_q;

endmodule

`default_nettype wire

// ===== hdl/cbm_datapath.sv =====
// cbm_datapath: mapper registers, address decode, IRQ timer and result register.
// Depends on cbm_pkg and cbm_mod_unit; driven by cbm_ctrl commands.
`default_nettype none

module cbm_datapath #(
	parameter int PRESCALE_PERIOD = cbm_pkg::PRESCALE_PERIOD_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire cbm_pkg::cbm_cmd_t               cmd,
	output cbm_pkg::cbm_stat_t                   stat,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [7:0]                      cfg_data,
	input  wire logic [1:0]                      op,
	input  wire logic [15:0]                     addr,
	input  wire logic [7:0]                      data,
	output logic [2:0]                           target,
	output logic [cbm_pkg::MEM_ADDR_W-1:0]       mem_addr,
	output logic                                 is_write,
	output logic [7:0]                           write_data,
	output logic [7:0]                           const_value,
	output logic                                 audio_write,
	output logic [7:0]                           audio_reg,
	output logic [1:0]                           mirror_mode,
	output logic                                 irq_pulse,
	output logic                                 unhandled
);

	localparam logic [cbm_pkg::PRESCALE_W-1:0] PERIOD = cbm_pkg::PRESCALE_W'(PRESCALE_PERIOD);

	logic [7:0] prg_count_q;
	logic [7:0] chr_count_q;
	logic [7:0] prg_sel_q [3];
	logic [7:0] chr_sel_q [8];
	logic [7:0] mirror_q;
	logic [7:0] aud_idx_q;
	logic [7:0] irq_lat_q;
	logic [7:0] irq_ctrl_q;
	logic [cbm_pkg::IRQ_COUNT_W-1:0] irq_cnt_q;
	logic [cbm_pkg::PRESCALE_W-1:0]  presc_q;

	logic [1:0]  op_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;

	logic [2:0]  target_q;
	logic [cbm_pkg::MEM_ADDR_W-1:0] mem_addr_q;
	logic        is_write_q;
	logic [7:0]  write_data_q;
	logic [7:0]  const_value_q;
	logic        audio_write_q;
	logic [7:0]  audio_reg_q;
	logic [1:0]  mirror_mode_q;
	logic        irq_pulse_q;
	logic        unhandled_q;

	logic [7:0]  prg_eff, chr_eff;
	logic        is_chr, is_sram, is_prg;
	logic [1:0]  win;
	logic [7:0]  mod_dividend, mod_divisor, mod_rem;
	logic        mod_done;
	logic [7:0]  prg_page;
	logic [15:0] dec;
	logic        dec_hit;
	logic        reg_wr;

	logic [2:0]  r_target;
	logic [cbm_pkg::MEM_ADDR_W-1:0] r_mem_addr;
	logic        r_is_write;
	logic [7:0]  r_write_data;
	logic [7:0]  r_const;
	logic        r_audio;
	logic        r_unhandled;
	logic        r_irq;
	logic [7:0]  mirror_next;

	logic [cbm_pkg::PRESCALE_W-1:0]  presc_inc;
	logic [cbm_pkg::IRQ_COUNT_W-1:0] irq_inc;

	assign prg_eff = (prg_count_q == 8'd0) ? 8'd1 : prg_count_q;
	assign chr_eff = (chr_count_q == 8'd0) ? 8'd1 : chr_count_q;
	assign is_chr  = (addr_q[15:13] == 3'b000);
	assign is_sram = (addr_q[15:13] == 3'b011);
	assign is_prg  = addr_q[15];
	assign win     = addr_q[14:13];

	assign mod_dividend = is_chr ? chr_sel_q[addr_q[12:10]] : prg_sel_q[win];
	assign mod_divisor  = is_chr ? chr_eff : prg_eff;

	assign stat.need_mod =
		(((op_q == cbm_pkg::OP_READ) || (op_q == cbm_pkg::OP_WRITE)) && is_chr)
		|| ((op_q == cbm_pkg::OP_READ) && is_prg && (win != 2'd3));
	assign stat.mod_done = mod_done;

	cbm_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (mod_dividend),
		.divisor   (mod_divisor),
		.remainder (mod_rem),
		.done      (mod_done)
	);

	assign prg_page = (win == 2'd3) ? 8'(prg_eff - 8'd1) : mod_rem;
	assign dec      = (addr_q | {11'b0, addr_q[3], 4'b0}) & cbm_pkg::DEC_MASK;
	assign reg_wr   = (op_q == cbm_pkg::OP_WRITE) && is_prg;

	always_comb begin
		unique case (dec)
			cbm_pkg::DEC_PRG0, cbm_pkg::DEC_PRG1, cbm_pkg::DEC_PRG2,
			cbm_pkg::DEC_AUD_IDX, cbm_pkg::DEC_AUD_DATA,
			cbm_pkg::DEC_CHR0, cbm_pkg::DEC_CHR1, cbm_pkg::DEC_CHR2, cbm_pkg::DEC_CHR3,
			cbm_pkg::DEC_CHR4, cbm_pkg::DEC_CHR5, cbm_pkg::DEC_CHR6, cbm_pkg::DEC_CHR7,
			cbm_pkg::DEC_MIRROR, cbm_pkg::DEC_IRQ_LAT,
			cbm_pkg::DEC_IRQ_CTRL, cbm_pkg::DEC_IRQ_ACK: dec_hit = 1'b1;
			default: dec_hit = 1'b0;
		endcase
	end

	assign presc_inc = presc_q + cbm_pkg::PRESCALE_W'(1);
	assign irq_inc   = irq_cnt_q + cbm_pkg::IRQ_COUNT_W'(1);

	always_comb begin
		r_target     = cbm_pkg::TGT_NONE;
		r_mem_addr   = '0;
		r_is_write   = 1'b0;
		r_write_data = '0;
		r_const      = '0;
		r_audio      = 1'b0;
		r_unhandled  = 1'b0;
		r_irq        = 1'b0;
		mirror_next  = mirror_q;
		unique case (op_q)
			cbm_pkg::OP_READ: begin
				if (is_chr) begin
					r_target   = cbm_pkg::TGT_CHR;
					r_mem_addr = {3'b000, mod_rem, addr_q[9:0]};
				end else if (is_sram) begin
					if (mirror_q[7]) begin
						r_target   = cbm_pkg::TGT_SRAM;
						r_mem_addr = {8'b0, addr_q[12:0]};
					end else begin
						r_target = cbm_pkg::TGT_CONST;
						r_const  = cbm_pkg::RAM_OFF_VAL;
					end
				end else if (is_prg) begin
					r_target   = cbm_pkg::TGT_PRG;
					r_mem_addr = {prg_page, addr_q[12:0]};
				end else begin
					r_target    = cbm_pkg::TGT_CONST;
					r_unhandled = 1'b1;
				end
			end
			cbm_pkg::OP_WRITE: begin
				if (is_chr) begin
					r_target     = cbm_pkg::TGT_CHR;
					r_mem_addr   = {3'b000, mod_rem, addr_q[9:0]};
					r_is_write   = 1'b1;
					r_write_data = data_q;
				end else if (is_sram) begin
					if (mirror_q[7]) begin
						r_target     = cbm_pkg::TGT_SRAM;
						r_mem_addr   = {8'b0, addr_q[12:0]};
						r_is_write   = 1'b1;
						r_write_data = data_q;
					end
				end else if (is_prg) begin
					r_unhandled = !dec_hit;
					if (dec == cbm_pkg::DEC_AUD_DATA) begin
						r_write_data = data_q;
						r_audio      = 1'b1;
					end
					if (dec == cbm_pkg::DEC_MIRROR) begin
						mirror_next = data_q & cbm_pkg::MIRROR_MASK;
					end
				end else begin
					r_unhandled = 1'b1;
				end
			end
			cbm_pkg::OP_TICK: begin
				r_irq = irq_ctrl_q[1] && (presc_inc >= PERIOD) && (irq_inc == cbm_pkg::IRQ_WRAP);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= 8'd1;
			chr_count_q <= 8'd1;
			for (int i = 0; i < 3; i++) prg_sel_q[i] <= '0;
			for (int i = 0; i < 8; i++) chr_sel_q[i] <= '0;
			mirror_q   <= '0;
			aud_idx_q  <= '0;
			irq_lat_q  <= '0;
			irq_ctrl_q <= '0;
			irq_cnt_q  <= '0;
			presc_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == cbm_pkg::CFG_PRG_COUNT) begin
					prg_count_q <= cfg_data;
				end else begin
					chr_count_q <= cfg_data;
				end
			end
			if (cmd.commit) begin
				mirror_q <= mirror_next;
				if (reg_wr) begin
					unique case (dec)
						cbm_pkg::DEC_PRG0:    prg_sel_q[0] <= data_q;
						cbm_pkg::DEC_PRG1:    prg_sel_q[1] <= data_q;
						cbm_pkg::DEC_PRG2:    prg_sel_q[2] <= data_q;
						cbm_pkg::DEC_AUD_IDX: aud_idx_q    <= data_q;
						cbm_pkg::DEC_CHR0:    chr_sel_q[0] <= data_q;
						cbm_pkg::DEC_CHR1:    chr_sel_q[1] <= data_q;
						cbm_pkg::DEC_CHR2:    chr_sel_q[2] <= data_q;
						cbm_pkg::DEC_CHR3:    chr_sel_q[3] <= data_q;
						cbm_pkg::DEC_CHR4:    chr_sel_q[4] <= data_q;
						cbm_pkg::DEC_CHR5:    chr_sel_q[5] <= data_q;
						cbm_pkg::DEC_CHR6:    chr_sel_q[6] <= data_q;
						cbm_pkg::DEC_CHR7:    chr_sel_q[7] <= data_q;
						cbm_pkg::DEC_IRQ_LAT: irq_lat_q    <= data_q;
						cbm_pkg::DEC_IRQ_CTRL: begin
							irq_ctrl_q <= data_q;
							presc_q    <= '0;
							if (data_q[1]) begin
								irq_cnt_q <= {1'b0, irq_lat_q};
							end
						end
						cbm_pkg::DEC_IRQ_ACK: irq_ctrl_q[1] <= irq_ctrl_q[0];
						default: begin
						end
					endcase
				end
				if ((op_q == cbm_pkg::OP_TICK) && irq_ctrl_q[1]) begin
					if (presc_inc >= PERIOD) begin
						presc_q <= presc_inc - PERIOD;
						if (irq_inc == cbm_pkg::IRQ_WRAP) begin
							irq_cnt_q <= {1'b0, irq_lat_q};
						end else begin
							irq_cnt_q <= irq_inc;
						end
					end else begin
						presc_q <= presc_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op;
			addr_q <= addr;
			data_q <= data;
		end
		if (cmd.commit) begin
			target_q      <= r_target;
			mem_addr_q    <= r_mem_addr;
			is_write_q    <= r_is_write;
			write_data_q  <= r_write_data;
			const_value_q <= r_const;
			audio_write_q <= r_audio;
			audio_reg_q   <= r_audio ? aud_idx_q : 8'd0;
			mirror_mode_q <= mirror_next[1:0];
			irq_pulse_q   <= r_irq;
			unhandled_q   <= r_unhandled;
		end
	end

	assign target      = target_q;
	assign mem_addr    = mem_addr_q;
	assign is_write    = is_write_q;
	assign write_data  = write_data_q;
	assign const_value = const_value_q;
	assign audio_write = audio_write_q;
	assign audio_reg   = audio_reg_q;
	assign mirror_mode = mirror_mode_q;
	assign irq_pulse   = irq_pulse_q;
	assign unhandled   = unhandled_q;

endmodule

`default_nettype wire

// ===== hdl/cbm_ctrl.sv =====
// cbm_ctrl: sequencer for one word at a time and the result valid flag.
// Depends on cbm_pkg; commands cbm_datapath.
`default_nettype none

module cbm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire cbm_pkg::cbm_stat_t stat,
	output cbm_pkg::cbm_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load_in   = 1'b0;
		cmd.mod_start = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				if (stat.need_mod) begin
					cmd.mod_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV: begin
				if (stat.mod_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== test/cartridge_bank_mapper_irq_test.sv =====
// cartridge_bank_mapper_irq_test: self-checking testbench of the cartridge bank mapper.
// Drives directed, random and timer words against a built-in predictor of the mapping,
// the register decode and the IRQ timer. Depends on cbm_pkg and cartridge_bank_mapper_irq.
module cartridge_bank_mapper_irq_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         TICK_PERIOD = cbm_pkg::PRESCALE_PERIOD_DEF;
	localparam int         CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [2:0]                     target;
		logic [cbm_pkg::MEM_ADDR_W-1:0] mem_addr;
		logic                           is_write;
		logic [7:0]                     write_data;
		logic [7:0]                     const_value;
		logic                           audio_write;
		logic [7:0]                     audio_reg;
		logic [1:0]                     mirror_mode;
		logic                           irq_pulse;
		logic                           unhandled;
	} access_t;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           cfg_we      = 1'b0;
	logic                           cfg_index   = 1'b0;
	logic [7:0]                     cfg_data    = 8'd0;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [1:0]                     op          = 2'd0;
	logic [15:0]                    addr        = 16'd0;
	logic [7:0]                     data        = 8'd0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic [2:0]                     target;
	logic [cbm_pkg::MEM_ADDR_W-1:0] mem_addr;
	logic                           is_write;
	logic [7:0]                     write_data;
	logic [7:0]                     const_value;
	logic                           audio_write;
	logic [7:0]                     audio_reg;
	logic [1:0]                     mirror_mode;
	logic                           irq_pulse;
	logic                           unhandled;

	// predictor state
	logic [7:0]                      prg_total = 8'd1;
	logic [7:0]                      chr_total = 8'd1;
	logic [7:0]                      prg_sel [3];
	logic [7:0]                      chr_sel [8];
	logic [7:0]                      mirror_reg;
	logic [7:0]                      audio_index;
	logic [7:0]                      irq_reload;
	logic [7:0]                      irq_ctrl;
	logic [cbm_pkg::IRQ_COUNT_W-1:0] irq_count;
	logic [cbm_pkg::PRESCALE_W-1:0]  prescale_count;

	access_t     pending_access [$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned reads_sent;
	int unsigned writes_sent;
	int unsigned ticks_sent;
	int unsigned pulses_seen;
	int unsigned count_writes;

	cartridge_bank_mapper_irq i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.addr        (addr),
		.data        (data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.target      (target),
		.mem_addr    (mem_addr),
		.is_write    (is_write),
		.write_data  (write_data),
		.const_value (const_value),
		.audio_write (audio_write),
		.audio_reg   (audio_reg),
		.mirror_mode (mirror_mode),
		.irq_pulse   (irq_pulse),
		.unhandled   (unhandled)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cartridge_bank_mapper_irq_test NOT OK");
			$finish;
		end
	end

	function automatic string fmt_access(input access_t r);
		return $sformatf({"tgt=%0d addr=%06h wr=%0d wd=%02h cv=%02h ",
			"aw=%0d ar=%02h mir=%0d irq=%0d unh=%0d"},
			r.target, r.mem_addr, r.is_write, r.write_data, r.const_value,
			r.audio_write, r.audio_reg, r.mirror_mode, r.irq_pulse, r.unhandled);
	endfunction

	function automatic int unsigned bank_limit(input logic [7:0] c);
		return (c == 8'd0) ? 1 : int'(c);
	endfunction

	function automatic int unsigned chr_offset(input logic [15:0] a);
		int unsigned bank;
		bank = int'(chr_sel[a[12:10]]) % bank_limit(chr_total);
		return bank * 1024 + int'(a[9:0]);
	endfunction

	function automatic access_t map_word(input logic [1:0] o, input logic [15:0] a,
			input logic [7:0] d);
		access_t     r;
		logic [15:0] dec;
		int unsigned bank;
		r = '0;
		case (o)
			cbm_pkg::OP_READ: begin
				if (a < 16'h2000) begin
					r.target   = cbm_pkg::TGT_CHR;
					r.mem_addr = cbm_pkg::MEM_ADDR_W'(chr_offset(a));
				end else if (a < 16'h6000) begin
					r.target    = cbm_pkg::TGT_CONST;
					r.unhandled = 1'b1;
				end else if (a < 16'h8000) begin
					if (mirror_reg[7]) begin
						r.target   = cbm_pkg::TGT_SRAM;
						r.mem_addr = {5'b0, 16'(a - 16'h6000)};
					end else begin
						r.target      = cbm_pkg::TGT_CONST;
						r.const_value = cbm_pkg::RAM_OFF_VAL;
					end
				end else begin
					if (a[14:13] == 2'd3)
						bank = bank_limit(prg_total) - 1;
					else
						bank = int'(prg_sel[a[14:13]]) % bank_limit(prg_total);
					r.target   = cbm_pkg::TGT_PRG;
					r.mem_addr = cbm_pkg::MEM_ADDR_W'(bank * 8192 + int'(a[12:0]));
				end
			end
			cbm_pkg::OP_WRITE: begin
				if (a < 16'h2000) begin
					r.target     = cbm_pkg::TGT_CHR;
					r.mem_addr   = cbm_pkg::MEM_ADDR_W'(chr_offset(a));
					r.is_write   = 1'b1;
					r.write_data = d;
				end else if (a < 16'h6000) begin
					r.unhandled = 1'b1;
				end else if (a < 16'h8000) begin
					if (mirror_reg[7]) begin
						r.target     = cbm_pkg::TGT_SRAM;
						r.mem_addr   = {5'b0, 16'(a - 16'h6000)};
						r.is_write   = 1'b1;
						r.write_data = d;
					end
				end else begin
					dec = (a | ((a & 16'h0008) << 1)) & cbm_pkg::DEC_MASK;
					case (dec)
						cbm_pkg::DEC_PRG0:     prg_sel[0] = d;
						cbm_pkg::DEC_PRG1:     prg_sel[1] = d;
						cbm_pkg::DEC_PRG2:     prg_sel[2] = d;
						cbm_pkg::DEC_AUD_IDX:  audio_index = d;
						cbm_pkg::DEC_AUD_DATA: begin
							r.write_data  = d;
							r.audio_write = 1'b1;
							r.audio_reg   = audio_index;
						end
						cbm_pkg::DEC_CHR0:     chr_sel[0] = d;
						cbm_pkg::DEC_CHR1:     chr_sel[1] = d;
						cbm_pkg::DEC_CHR2:     chr_sel[2] = d;
						cbm_pkg::DEC_CHR3:     chr_sel[3] = d;
						cbm_pkg::DEC_CHR4:     chr_sel[4] = d;
						cbm_pkg::DEC_CHR5:     chr_sel[5] = d;
						cbm_pkg::DEC_CHR6:     chr_sel[6] = d;
						cbm_pkg::DEC_CHR7:     chr_sel[7] = d;
						cbm_pkg::DEC_MIRROR:   mirror_reg = d & cbm_pkg::MIRROR_MASK;
						cbm_pkg::DEC_IRQ_LAT:  irq_reload = d;
						cbm_pkg::DEC_IRQ_CTRL: begin
							irq_ctrl       = d;
							prescale_count = '0;
							if (d[1])
								irq_count = {1'b0, irq_reload};
						end
						cbm_pkg::DEC_IRQ_ACK:  irq_ctrl[1] = irq_ctrl[0];
						default:               r.unhandled = 1'b1;
					endcase
				end
			end
			cbm_pkg::OP_TICK: begin
				if (irq_ctrl[1]) begin
					prescale_count = prescale_count + cbm_pkg::PRESCALE_W'(1);
					if (prescale_count >= TICK_PERIOD) begin
						prescale_count = cbm_pkg::PRESCALE_W'(prescale_count - TICK_PERIOD);
						irq_count      = irq_count + cbm_pkg::IRQ_COUNT_W'(1);
						if (irq_count == cbm_pkg::IRQ_WRAP) begin
							irq_count   = {1'b0, irq_reload};
							r.irq_pulse = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		r.mirror_mode = mirror_reg[1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		access_t got;
		access_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {target, mem_addr, is_write, write_data, const_value,
				audio_write, audio_reg, mirror_mode, irq_pulse, unhandled};
			if (pending_access.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with no word pending: %s", fmt_access(got));
			end else begin
				want = pending_access.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch: expected %s", fmt_access(want));
						$display("          actual   %s", fmt_access(got));
					end
				end
			end
		end
	end

	task automatic send_word(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d);
		access_t r;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		addr     <= a;
		data     <= d;
		do
			@(posedge clk);
		while (!in_ready);
		r = map_word(o, a, d);
		pending_access.insert(pending_access.size(), r);
		if (r.irq_pulse)
			pulses_seen++;
		case (o)
			cbm_pkg::OP_READ:  reads_sent++;
			cbm_pkg::OP_WRITE: writes_sent++;
			cbm_pkg::OP_TICK:  ticks_sent++;
			default:           ;
		endcase
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_access.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_bank_count(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == cbm_pkg::CFG_PRG_COUNT)
			prg_total = val;
		else
			chr_total = val;
		count_writes++;
	endtask

	task automatic test_directed();
		send_word(cbm_pkg::OP_READ, 16'h0000, 8'h00);
		send_word(cbm_pkg::OP_READ, 16'h1FFF, 8'hFF);
		send_word(cbm_pkg::OP_READ, 16'h2000, 8'h00);
		send_word(cbm_pkg::OP_READ, 16'h5FFF, 8'h00);
		send_word(cbm_pkg::OP_READ, 16'h6000, 8'h00);
		send_word(cbm_pkg::OP_WRITE, 16'h7FFF, 8'hAA);
		send_word(cbm_pkg::OP_WRITE, 16'h3000, 8'h55);
		send_word(cbm_pkg::OP_TICK, 16'hFFFF, 8'hFF);
		send_word(OP_UNUSED, 16'hFFFF, 8'hFF);
		wait_drain();
		send_word(cbm_pkg::OP_WRITE, 16'hE000, 8'hFF);
		send_word(cbm_pkg::OP_READ, 16'h6000, 8'h00);
		send_word(cbm_pkg::OP_WRITE, 16'h7FFF, 8'hFF);
		send_word(cbm_pkg::OP_WRITE, 16'h8000, 8'hFF);
		send_word(cbm_pkg::OP_WRITE, 16'h8008, 8'h7F);
		send_word(cbm_pkg::OP_WRITE, 16'h9010, 8'h25);
		send_word(cbm_pkg::OP_WRITE, 16'h9030, 8'h81);
		send_word(cbm_pkg::OP_WRITE, 16'h8020, 8'h11);
		send_word(cbm_pkg::OP_WRITE, 16'hA000, 8'hFF);
		send_word(cbm_pkg::OP_WRITE, 16'h0000, 8'h00);
		send_word(cbm_pkg::OP_READ, 16'hFFFF, 8'h00);
		send_word(cbm_pkg::OP_READ, 16'hA123, 8'h00);
		send_word(cbm_pkg::OP_WRITE, 16'hE010, 8'h12);
		send_word(cbm_pkg::OP_WRITE, 16'hF000, 8'h07);
		send_word(cbm_pkg::OP_TICK, 16'h0000, 8'h00);
		send_word(cbm_pkg::OP_WRITE, 16'hF010, 8'h00);
	endtask

	task automatic test_random_mix(input int unsigned n);
		int unsigned pick;
		logic [1:0]  o;
		logic [15:0] a;
		for (int unsigned i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			o = (pick < 30) ? cbm_pkg::OP_READ : (pick < 75) ? cbm_pkg::OP_WRITE :
				(pick < 96) ? cbm_pkg::OP_TICK : OP_UNUSED;
			pick = $urandom_range(7);
			case (pick)
				0, 1:    a = {3'b000, 13'($urandom)};
				2:       a = 16'($urandom_range(16'h2000, 16'h5FFF));
				3:       a = {3'b011, 13'($urandom)};
				default: a = {1'b1, 15'($urandom)};
			endcase
			send_word(o, a, 8'($urandom));
			if ($urandom_range(59) == 0)
				wait_drain();
		end
	endtask

	task automatic test_irq_timer();
		send_word(cbm_pkg::OP_WRITE, 16'hE010 | (16'($urandom) & 16'h0FC7), 8'hFF);
		send_word(cbm_pkg::OP_WRITE, 16'hF000 | (16'($urandom) & 16'h0FC7),
			{6'($urandom), 2'b11});
		for (int unsigned k = 0; k < TICK_PERIOD + 20; k++) begin
			if ($urandom_range(19) == 0)
				send_word(cbm_pkg::OP_READ, 16'($urandom), 8'($urandom));
			if (k == 200)
				send_word(cbm_pkg::OP_WRITE, 16'hF010 | (16'($urandom) & 16'h0FCF),
					8'($urandom));
			send_word(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int unsigned phase;
		for (int i = 0; i < 3; i++)
			prg_sel[i] = 8'd0;
		for (int i = 0; i < 8; i++)
			chr_sel[i] = 8'd0;
		mirror_reg     = '0;
		audio_index    = '0;
		irq_reload     = '0;
		irq_ctrl       = '0;
		irq_count      = '0;
		prescale_count = '0;
		send_idle_pct  = 8;
		recv_idle_pct  = 47;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		for (phase = 0; phase < 3; phase++) begin
			wait_drain();
			case (phase)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 47;
					set_bank_count(cbm_pkg::CFG_PRG_COUNT, 8'd255);
					set_bank_count(cbm_pkg::CFG_CHR_COUNT, 8'd0);
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 8;
					set_bank_count(cbm_pkg::CFG_PRG_COUNT, 8'd0);
					set_bank_count(cbm_pkg::CFG_CHR_COUNT, 8'd255);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					set_bank_count(cbm_pkg::CFG_PRG_COUNT, 8'($urandom_range(1, 254)));
					set_bank_count(cbm_pkg::CFG_CHR_COUNT, 8'($urandom_range(1, 254)));
				end
			endcase
			test_random_mix(30);
			wait_drain();
			set_bank_count(cbm_pkg::CFG_PRG_COUNT, 8'($urandom_range(1, 255)));
			set_bank_count(cbm_pkg::CFG_CHR_COUNT, 8'($urandom_range(1, 255)));
			test_irq_timer();
		end

		wait_drain();
		repeat (16) @(negedge clk);
		$display("words sent: %0d reads, %0d writes, %0d ticks; %0d irq pulses expected",
			reads_sent, writes_sent, ticks_sent, pulses_seen);
		$display("bank count writes: %0d, mismatches: %0d", count_writes, mismatch_count);
		if (mismatch_count == 0 && pending_access.size() == 0)
			$display("cartridge_bank_mapper_irq_test OK");
		else
			$display("cartridge_bank_mapper_irq_test NOT OK");
		$finish;
	end
endmodule
